/* rtl/wcl_pkg.sv */
`timescale 1ns / 1ps

package wcl_pkg;

   localparam int unsigned LAG_COUNT_BITS_DEF = 18;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 18;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_A_OFFSET       = 3'd0,
      REG_B_OFFSET       = 3'd1,
      REG_WINDOW_AMOUNT  = 3'd2,
      REG_LAG_AMOUNT     = 3'd3,
      REG_BIPOLAR_OUTPUT = 3'd4,
      REG_SAMPLE_RATE    = 3'd5
   } reg_index_type;

   localparam logic signed [11:0] A_OFFSET_RST      = 12'sd0;
   localparam logic signed [11:0] B_OFFSET_RST      = 12'sd0;
   localparam logic [10:0]        WINDOW_AMOUNT_RST = 11'd512;
   localparam logic [10:0]        LAG_AMOUNT_RST    = 11'd102;
   localparam logic [17:0]        SAMPLE_RATE_RST   = 18'd44100;

   // datapath widths
   localparam int unsigned MUL_W  = 26;
   localparam int unsigned PROD_W = 2 * MUL_W;
   localparam int unsigned UNIT_W = 27;
   localparam int unsigned LEVEL_W = 15;

   // voltages are in mV/1024 units inside the block
   localparam logic signed [UNIT_W-1:0] CLAMP_UNITS = 27'sd12288000;
   localparam logic signed [15:0]       FULL_SCALE_SIGNED = 16'sd10000;
   localparam logic [13:0]              FULL_SCALE_MV = 14'd10000;
   localparam logic signed [MUL_W-1:0]  KNOB_SCALE = 26'sd10000;

   // lag = floor(p^2 * rate / (2^28 * 390625)), quotient fits 21 bits
   localparam int unsigned QUO_W = 21;
   localparam int unsigned REM_W = 19;
   localparam logic [REM_W:0] DIVISOR = 20'd390625;

   // dividend after the 2^28 drop, and the scaled reciprocal of the divisor;
   // the estimate from the top 25 dividend bits is at most one below the quotient
   localparam int unsigned NUM_W       = 39;
   localparam int unsigned NUM_DROP    = 14;
   localparam int unsigned RECIP_SHIFT = 29;
   localparam logic [24:0] RECIP =
      25'((64'd1 << (NUM_DROP + RECIP_SHIFT)) / 64'(DIVISOR));

   localparam logic signed [LEVEL_W-1:0] LEVEL_UNI_HI = 15'sd10000;
   localparam logic signed [LEVEL_W-1:0] LEVEL_UNI_LO = 15'sd0;
   localparam logic signed [LEVEL_W-1:0] LEVEL_BI_HI  = 15'sd5000;
   localparam logic signed [LEVEL_W-1:0] LEVEL_BI_LO  = -15'sd5000;

   typedef enum logic [3:0] {
      MODE_LOW      = 4'b0001,
      MODE_HIGH     = 4'b0010,
      MODE_LAG_HIGH = 4'b0100,
      MODE_LAG_LOW  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic step;
      logic cond;
   } chan_ctl_type;

endpackage

/* rtl/wcl_ifs.sv */
`timescale 1ns / 1ps

interface wcl_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] a_cv;
   logic               a_connected;
   logic signed [15:0] b_cv;
   logic               b_connected;
   logic signed [15:0] window_cv;
   logic               window_connected;
   logic signed [15:0] lag_cv;
   logic               lag_connected;

   modport source (
      output valid, a_cv, a_connected, b_cv, b_connected,
      output window_cv, window_connected, lag_cv, lag_connected,
      input  ready
   );
   modport sink (
      input  valid, a_cv, a_connected, b_cv, b_connected,
      input  window_cv, window_connected, lag_cv, lag_connected,
      output ready
   );
endinterface

interface wcl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] greater_level;
   logic signed [14:0] less_level;
   logic signed [14:0] equal_level;
   logic signed [14:0] not_equal_level;

   modport source (
      output valid, greater_level, less_level, equal_level, not_equal_level,
      input  ready
   );
   modport sink (
      input  valid, greater_level, less_level, equal_level, not_equal_level,
      output ready
   );
endinterface

interface wcl_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [17:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wcl_channel.sv */
`timescale 1ns / 1ps

module wcl_channel #(
   parameter int unsigned LAG_COUNT_BITS = wcl_pkg::LAG_COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wcl_pkg::chan_ctl_type     ctl,
   input  logic [LAG_COUNT_BITS-1:0] lag,
   output logic                      true_next
);
   import wcl_pkg::*;

   mode_type                  mode_ff, mode_in;
   logic [LAG_COUNT_BITS-1:0] count_ff, count_in;
   logic [LAG_COUNT_BITS-1:0] count_dec;
   logic                      lag_zero;

   assign count_dec = count_ff - LAG_COUNT_BITS'(1);
   assign lag_zero  = (lag == '0);

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (ctl.step) begin
         unique case (mode_ff)
            MODE_LOW: begin
               if (ctl.cond) begin
                  mode_in  = lag_zero ? MODE_HIGH : MODE_LAG_HIGH;
                  count_in = lag_zero ? count_ff : lag;
               end
            end
            MODE_HIGH: begin
               if (!ctl.cond) begin
                  mode_in  = lag_zero ? MODE_LOW : MODE_LAG_LOW;
                  count_in = lag_zero ? count_ff : lag;
               end
            end
            MODE_LAG_LOW: begin
               if (!ctl.cond) begin
                  count_in = count_dec;
                  if (count_dec == '0) mode_in = MODE_LOW;
               end else begin
                  mode_in = MODE_HIGH;
               end
            end
            MODE_LAG_HIGH: begin
               if (ctl.cond) begin
                  count_in = count_dec;
                  if (count_dec == '0) mode_in = MODE_HIGH;
               end else begin
                  mode_in = MODE_LOW;
               end
            end
            default: mode_in = MODE_LOW;
         endcase
      end
   end

   // the gate reads true while high or while a fall is still pending
   assign true_next = (mode_in == MODE_HIGH) || (mode_in == MODE_LAG_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_LOW;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/window_comparator_with_lag_top.sv */
`timescale 1ns / 1ps

// Window comparator with lag. Each accepted word carries the A, B, window and
// lag CVs; the block answers with one word of four gate levels in mV
// (greater/less from A >= B, equal/not-equal from |A - B| <= window), each
// gate changing only after its new condition has held for the lag in
// samples. The block works on one word at a time: a new word is accepted
// only once the previous one has finished. A single 26x26 multiplier is
// stepped through seven products (knob scaling, window, lag knob times CV,
// its square and the two halves of the square times the sample rate), a
// sum step adds the two halves, and the division by 390625 that turns that
// product into the lag count follows as a multiply by a scaled reciprocal,
// a multiply back and a one-step correction, then an update step updates
// the gates. The input is ready again once the result is in the output
// register; if that register is still full, the block holds the finished
// word until it is taken. Configuration writes are taken at any time and
// must be done while the block is idle.
module window_comparator_with_lag_top #(
   parameter int unsigned LAG_COUNT_BITS = wcl_pkg::LAG_COUNT_BITS_DEF
) (
   input logic clock,
   input logic reset,
   wcl_req_if.sink   req_chan,
   wcl_rsp_if.source rsp_chan,
   wcl_csr_if.sink   csr_chan
);
   import wcl_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_AMUL   = 13'b0000000000010,
      ST_BMUL   = 13'b0000000000100,
      ST_WMUL   = 13'b0000000001000,
      ST_PMUL   = 13'b0000000010000,
      ST_SQMUL  = 13'b0000000100000,
      ST_LOMUL  = 13'b0000001000000,
      ST_HIMUL  = 13'b0000010000000,
      ST_SUM    = 13'b0000100000000,
      ST_QMUL   = 13'b0001000000000,
      ST_BACK   = 13'b0010000000000,
      ST_FIX    = 13'b0100000000000,
      ST_UPDATE = 13'b1000000000000
   } step_type;

   // configuration
   logic signed [11:0] a_offset_ff, b_offset_ff;
   logic [10:0]        window_amount_ff, lag_amount_ff;
   logic               bipolar_ff;
   logic [17:0]        sample_rate_ff;

   // captured word
   logic signed [15:0] a_cv_ff, b_cv_ff, window_cv_ff, lag_cv_ff;
   logic               a_conn_ff, b_conn_ff, window_conn_ff, lag_conn_ff;

   step_type                 step_ff, step_in;
   logic                     accept;
   logic                     commit;

   // shared multiplier
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod_in, prod_ff;

   // shared level adder and clamp
   logic signed [15:0]       lvl_cv;
   logic                     lvl_conn;
   logic signed [UNIT_W-1:0] lvl_knob, lvl_sum, lvl_out;

   logic signed [UNIT_W-1:0] a_ff, b_ff;
   logic [24:0]              win_ff;
   logic [24:0]              sq_hi_ff;
   logic [42:0]              acc_ff;
   logic [66:0]              big_sum;
   logic [13:0]              w_scale, l_scale;

   logic                     th_ff;
   logic [UNIT_W-2:0]        absdiff_ff;
   logic signed [UNIT_W-1:0] diff_ab, diff_ba;

   // division by the constant
   logic [NUM_W-1:0]         num_ff;
   logic [NUM_W-1:0]         fix_rem;
   logic [QUO_W-1:0]         quo_ff, quo_in;

   logic [LAG_COUNT_BITS-1:0] lag;
   logic                      wn_cond;
   logic                      th_true, wn_true;
   chan_ctl_type              th_ctl, wn_ctl;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] greater_ff, less_ff, equal_ff, not_equal_ff;
   logic signed [LEVEL_W-1:0] hi_v, lo_v;

   function automatic logic [13:0] clamp_scale(input logic signed [15:0] v);
      logic [13:0] r;
      if (v[15]) r = '0;
      else if (v > FULL_SCALE_SIGNED) r = FULL_SCALE_MV;
      else r = v[13:0];
      return r;
   endfunction

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (step_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign commit         = (step_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer
   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         ST_IDLE:   if (accept) step_in = ST_AMUL;
         ST_AMUL:   step_in = ST_BMUL;
         ST_BMUL:   step_in = ST_WMUL;
         ST_WMUL:   step_in = ST_PMUL;
         ST_PMUL:   step_in = ST_SQMUL;
         ST_SQMUL:  step_in = ST_LOMUL;
         ST_LOMUL:  step_in = ST_HIMUL;
         ST_HIMUL:  step_in = ST_SUM;
         ST_SUM:    step_in = ST_QMUL;
         ST_QMUL:   step_in = ST_BACK;
         ST_BACK:   step_in = ST_FIX;
         ST_FIX:    step_in = ST_UPDATE;
         ST_UPDATE: if (commit) step_in = ST_IDLE;
         default:   step_in = ST_IDLE;
      endcase
   end

   assign w_scale = window_conn_ff ? clamp_scale(window_cv_ff) : FULL_SCALE_MV;
   assign l_scale = lag_conn_ff ? clamp_scale(lag_cv_ff) : FULL_SCALE_MV;

   // operand select for the multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         ST_AMUL: begin
            op_a = {{(MUL_W - 12){a_offset_ff[11]}}, a_offset_ff};
            op_b = KNOB_SCALE;
         end
         ST_BMUL: begin
            op_a = {{(MUL_W - 12){b_offset_ff[11]}}, b_offset_ff};
            op_b = KNOB_SCALE;
         end
         ST_WMUL: begin
            op_a = {15'd0, window_amount_ff};
            op_b = {12'd0, w_scale};
         end
         ST_PMUL: begin
            op_a = {15'd0, lag_amount_ff};
            op_b = {12'd0, l_scale};
         end
         ST_SQMUL: begin
            op_a = {1'b0, prod_ff[24:0]};
            op_b = {1'b0, prod_ff[24:0]};
         end
         ST_LOMUL: begin
            op_a = {1'b0, prod_ff[24:0]};
            op_b = {8'd0, sample_rate_ff};
         end
         ST_HIMUL: begin
            op_a = {1'b0, sq_hi_ff};
            op_b = {8'd0, sample_rate_ff};
         end
         ST_QMUL: begin
            op_a = {1'b0, num_ff[NUM_W-1:NUM_DROP]};
            op_b = {1'b0, RECIP};
         end
         ST_BACK: begin
            op_a = {5'd0, prod_ff[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT]};
            op_b = {6'd0, DIVISOR};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   // knob product plus CV, clamped to +-12 V when the CV is patched
   assign lvl_cv   = (step_ff == ST_BMUL) ? a_cv_ff : b_cv_ff;
   assign lvl_conn = (step_ff == ST_BMUL) ? a_conn_ff : b_conn_ff;
   assign lvl_knob = {prod_ff[MUL_W-1], prod_ff[MUL_W-1:0]};
   assign lvl_sum  = lvl_knob + {lvl_cv[15], lvl_cv, 10'd0};

   always_comb begin
      if (!lvl_conn) lvl_out = lvl_knob;
      else if (lvl_sum > CLAMP_UNITS) lvl_out = CLAMP_UNITS;
      else if (lvl_sum < -CLAMP_UNITS) lvl_out = -CLAMP_UNITS;
      else lvl_out = lvl_sum;
   end

   // full square times rate, the low 28 bits drop out of the quotient
   assign big_sum = {prod_ff[41:0], 25'd0} + {24'd0, acc_ff};
   assign diff_ab = a_ff - b_ff;
   assign diff_ba = b_ff - a_ff;

   // reciprocal estimate, then one compare and subtract settles the quotient
   assign fix_rem = num_ff - prod_ff[NUM_W-1:0];

   always_comb begin
      quo_in = quo_ff;
      if (step_ff == ST_BACK) begin
         quo_in = prod_ff[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
      end else if ((step_ff == ST_FIX) && (fix_rem >= NUM_W'(DIVISOR))) begin
         quo_in = quo_ff + QUO_W'(1);
      end
   end

   generate
      if (LAG_COUNT_BITS >= QUO_W) begin : g_lag_wide
         assign lag = LAG_COUNT_BITS'(quo_ff);
      end else begin : g_lag_sat
         assign lag = (|quo_ff[QUO_W-1:LAG_COUNT_BITS]) ? '1 : quo_ff[LAG_COUNT_BITS-1:0];
      end
   endgenerate

   assign wn_cond     = (absdiff_ff <= {1'b0, win_ff});
   assign th_ctl.step = commit;
   assign th_ctl.cond = th_ff;
   assign wn_ctl.step = commit;
   assign wn_ctl.cond = wn_cond;

   wcl_channel #(
      .LAG_COUNT_BITS(LAG_COUNT_BITS)
   ) u_threshold (
      .clock    (clock),
      .reset    (reset),
      .ctl      (th_ctl),
      .lag      (lag),
      .true_next(th_true)
   );

   wcl_channel #(
      .LAG_COUNT_BITS(LAG_COUNT_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctl      (wn_ctl),
      .lag      (lag),
      .true_next(wn_true)
   );

   assign hi_v = bipolar_ff ? LEVEL_BI_HI : LEVEL_UNI_HI;
   assign lo_v = bipolar_ff ? LEVEL_BI_LO : LEVEL_UNI_LO;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (commit) rsp_valid_in = 1'b1;
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         a_offset_ff      <= A_OFFSET_RST;
         b_offset_ff      <= B_OFFSET_RST;
         window_amount_ff <= WINDOW_AMOUNT_RST;
         lag_amount_ff    <= LAG_AMOUNT_RST;
         bipolar_ff       <= 1'b0;
         sample_rate_ff   <= SAMPLE_RATE_RST;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               REG_A_OFFSET:       a_offset_ff      <= csr_chan.data[11:0];
               REG_B_OFFSET:       b_offset_ff      <= csr_chan.data[11:0];
               REG_WINDOW_AMOUNT:  window_amount_ff <= csr_chan.data[10:0];
               REG_LAG_AMOUNT:     lag_amount_ff    <= csr_chan.data[10:0];
               REG_BIPOLAR_OUTPUT: bipolar_ff       <= csr_chan.data[0];
               REG_SAMPLE_RATE:    sample_rate_ff   <= csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      if (accept) begin
         a_cv_ff        <= req_chan.a_cv;
         a_conn_ff      <= req_chan.a_connected;
         b_cv_ff        <= req_chan.b_cv;
         b_conn_ff      <= req_chan.b_connected;
         window_cv_ff   <= req_chan.window_cv;
         window_conn_ff <= req_chan.window_connected;
         lag_cv_ff      <= req_chan.lag_cv;
         lag_conn_ff    <= req_chan.lag_connected;
      end
      if (step_ff == ST_BMUL) a_ff <= lvl_out;
      if (step_ff == ST_WMUL) b_ff <= lvl_out;
      if (step_ff == ST_PMUL) win_ff <= prod_ff[24:0];
      if (step_ff == ST_LOMUL) sq_hi_ff <= prod_ff[49:25];
      if (step_ff == ST_HIMUL) acc_ff <= prod_ff[42:0];
      if (step_ff == ST_SUM) begin
         num_ff     <= big_sum[66:28];
         th_ff      <= (a_ff >= b_ff);
         absdiff_ff <= (a_ff >= b_ff) ? diff_ab[UNIT_W-2:0] : diff_ba[UNIT_W-2:0];
      end
      if (commit) begin
         greater_ff   <= th_true ? hi_v : lo_v;
         less_ff      <= th_true ? lo_v : hi_v;
         equal_ff     <= wn_true ? hi_v : lo_v;
         not_equal_ff <= wn_true ? lo_v : hi_v;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.greater_level   = greater_ff;
   assign rsp_chan.less_level      = less_ff;
   assign rsp_chan.equal_level     = equal_ff;
   assign rsp_chan.not_equal_level = not_equal_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("input ready right after accepting a word");

   a_fix_in_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_FIX) |-> (fix_rem < NUM_W'({DIVISOR, 1'b0})))
      else $error("reciprocal estimate off by more than one");

   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == ST_UPDATE))
      else $error("result raised outside the update step");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_UPDATE) && rsp_valid_ff && !rsp_chan.ready |=> (step_ff == ST_UPDATE))
      else $error("finished word dropped while output was full");

endmodule

/* tb/tb_window_comparator_with_lag_top.sv */
`timescale 1ns / 1ps

module tb_window_comparator_with_lag_top;
   import wcl_pkg::*;

   localparam int unsigned CNT_W = LAG_COUNT_BITS_DEF;
   localparam longint unsigned LAG_LIMIT = (64'd1 << CNT_W) - 1;
   localparam longint CLAMP_LIMIT = 64'sd12000 * 64'sd1024;
   localparam logic [2:0] SPARE_INDEX_A = 3'd6;
   localparam logic [2:0] SPARE_INDEX_B = 3'd7;
   localparam logic signed [14:0] UHI = LEVEL_UNI_HI;
   localparam logic signed [14:0] ULO = LEVEL_UNI_LO;

   typedef struct {
      logic signed [15:0] a_cv;
      logic               a_connected;
      logic signed [15:0] b_cv;
      logic               b_connected;
      logic signed [15:0] window_cv;
      logic               window_connected;
      logic signed [15:0] lag_cv;
      logic               lag_connected;
   } sample_type;

   typedef struct {
      logic signed [14:0] greater_level;
      logic signed [14:0] less_level;
      logic signed [14:0] equal_level;
      logic signed [14:0] not_equal_level;
   } levels_type;

   typedef struct {
      logic signed [15:0] a_cv;
      logic               a_connected;
      logic signed [15:0] b_cv;
      logic               b_connected;
      logic signed [15:0] window_cv;
      logic               window_connected;
      logic signed [15:0] lag_cv;
      logic               lag_connected;
      logic               known;
      logic signed [14:0] greater_level;
      logic signed [14:0] less_level;
      logic signed [14:0] equal_level;
      logic signed [14:0] not_equal_level;
   } vector_type;

   typedef struct {
      logic signed [11:0] a_offset;
      logic signed [11:0] b_offset;
      logic [10:0]        window_amount;
      logic [10:0]        lag_amount;
      logic               bipolar;
      logic [17:0]        sample_rate;
   } setting_type;

   logic clock;
   logic reset;

   wcl_req_if req_bus ();
   wcl_rsp_if rsp_bus ();
   wcl_csr_if csr_bus ();

   window_comparator_with_lag_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // register copies and gate state of the predictor
   logic signed [11:0] cfg_a_offset = A_OFFSET_RST;
   logic signed [11:0] cfg_b_offset = B_OFFSET_RST;
   logic [10:0]        cfg_window_amount = WINDOW_AMOUNT_RST;
   logic [10:0]        cfg_lag_amount = LAG_AMOUNT_RST;
   logic               cfg_bipolar = 1'b0;
   logic [17:0]        cfg_sample_rate = SAMPLE_RATE_RST;
   mode_type           gate_mode [2] = '{MODE_LOW, MODE_LOW};
   logic [CNT_W-1:0]   gate_count [2] = '{'0, '0};

   levels_type pending_levels [$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold = 0;

   // directed words at reset settings; the first rows start from the low modes
   vector_type directed_tab [16] = '{
      '{-32768, 0, 32767, 0, -32768, 0, 32767, 0, 1, ULO, UHI, ULO, UHI},
      '{-1, 1, 0, 0, 0, 0, 0, 1, 1, ULO, UHI, ULO, UHI},
      '{0, 1, 0, 0, 0, 0, 0, 1, 1, UHI, ULO, ULO, UHI},
      '{32767, 1, -32768, 1, 0, 1, 0, 1, 1, UHI, ULO, ULO, UHI},
      '{-32768, 1, 32767, 1, -32768, 1, -32768, 1, 1, ULO, UHI, ULO, UHI},
      '{5000, 1, 5000, 1, 0, 1, 0, 1, 1, UHI, ULO, UHI, ULO},
      '{6000, 1, 1000, 1, 32767, 1, 0, 1, 1, UHI, ULO, UHI, ULO},
      '{6001, 1, 1000, 1, 32767, 1, 0, 1, 1, UHI, ULO, ULO, UHI},
      '{1000, 1, 6000, 1, 0, 0, 10000, 1, 1, UHI, ULO, ULO, UHI},
      '{6000, 1, 1000, 1, 0, 0, 10000, 1, 1, UHI, ULO, ULO, UHI},
      '{6000, 1, 1000, 1, 0, 1, 10000, 1, 1, UHI, ULO, ULO, UHI},
      '{1000, 1, 1200, 1, 0, 0, 700, 1, 0, 0, 0, 0, 0},
      '{1000, 1, 1200, 1, 0, 0, 700, 1, 0, 0, 0, 0, 0},
      '{1000, 1, 1200, 1, 0, 0, 700, 1, 0, 0, 0, 0, 0},
      '{1000, 1, 1200, 1, 0, 0, 700, 1, 0, 0, 0, 0, 0},
      '{32767, 0, -32768, 1, 10000, 1, 0, 0, 0, 0, 0, 0, 0}
   };

   // range extremes, zero lag, saturated lag, zero sample rate
   setting_type fixed_settings [5] = '{
      '{0, 0, 512, 1024, 0, 16},
      '{1024, -1024, 1024, 1024, 1, 8},
      '{-1024, 1024, 0, 0, 0, 44100},
      '{2047, -2048, 2047, 2047, 1, 262143},
      '{100, -50, 300, 512, 0, 0}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_window_comparator_with_lag_top failed");
      $finish;
   end

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [CNT_W-1:0] lag_samples(logic con, logic signed [15:0] cv);
      longint unsigned knob, rate, c, p, sq, x;
      knob = 64'(cfg_lag_amount);
      rate = 64'(cfg_sample_rate);
      if (con) begin
         c = clamp_to(longint'(cv), 0, 10000);
         p = knob * c;
         sq = p * p;
         x = ((sq / 64'd100000000) * rate + ((sq % 64'd100000000) * rate) / 64'd100000000) >> 20;
      end else begin
         x = (knob * knob * rate) >> 20;
      end
      if (x > LAG_LIMIT) x = LAG_LIMIT;
      return CNT_W'(x);
   endfunction

   function automatic void step_gate(int ch, bit cond, logic [CNT_W-1:0] lag);
      case (gate_mode[ch])
         MODE_LOW: begin
            if (cond) begin
               if (lag == 0) gate_mode[ch] = MODE_HIGH;
               else begin
                  gate_mode[ch] = MODE_LAG_HIGH;
                  gate_count[ch] = lag;
               end
            end
         end
         MODE_HIGH: begin
            if (!cond) begin
               if (lag == 0) gate_mode[ch] = MODE_LOW;
               else begin
                  gate_mode[ch] = MODE_LAG_LOW;
                  gate_count[ch] = lag;
               end
            end
         end
         MODE_LAG_LOW: begin
            if (!cond) begin
               gate_count[ch] = gate_count[ch] - 1'b1;
               if (gate_count[ch] == 0) gate_mode[ch] = MODE_LOW;
            end else begin
               gate_mode[ch] = MODE_HIGH;
            end
         end
         default: begin
            if (cond) begin
               gate_count[ch] = gate_count[ch] - 1'b1;
               if (gate_count[ch] == 0) gate_mode[ch] = MODE_HIGH;
            end else begin
               gate_mode[ch] = MODE_LOW;
            end
         end
      endcase
   endfunction

   // voltages in mV/1024 so every comparison is exact
   function automatic levels_type gate_levels_for(sample_type s);
      longint a_u, b_u, win_u, diff_u;
      logic [CNT_W-1:0] lag;
      logic signed [14:0] on_mv, off_mv;
      bit th_true, wn_true;
      levels_type lv;
      a_u = longint'(cfg_a_offset) * 10000;
      b_u = longint'(cfg_b_offset) * 10000;
      if (s.a_connected)
         a_u = clamp_to(a_u + longint'(s.a_cv) * 1024, -CLAMP_LIMIT, CLAMP_LIMIT);
      if (s.b_connected)
         b_u = clamp_to(b_u + longint'(s.b_cv) * 1024, -CLAMP_LIMIT, CLAMP_LIMIT);
      win_u = longint'(cfg_window_amount)
            * (s.window_connected ? clamp_to(longint'(s.window_cv), 0, 10000) : 64'sd10000);
      diff_u = a_u - b_u;
      if (diff_u < 0) diff_u = -diff_u;
      lag = lag_samples(s.lag_connected, s.lag_cv);
      step_gate(0, a_u >= b_u, lag);
      step_gate(1, diff_u <= win_u, lag);
      on_mv = cfg_bipolar ? LEVEL_BI_HI : LEVEL_UNI_HI;
      off_mv = cfg_bipolar ? LEVEL_BI_LO : LEVEL_UNI_LO;
      th_true = gate_mode[0] inside {MODE_HIGH, MODE_LAG_LOW};
      wn_true = gate_mode[1] inside {MODE_HIGH, MODE_LAG_LOW};
      lv.greater_level = th_true ? on_mv : off_mv;
      lv.less_level = th_true ? off_mv : on_mv;
      lv.equal_level = wn_true ? on_mv : off_mv;
      lv.not_equal_level = wn_true ? off_mv : on_mv;
      return lv;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < 50) $display("%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_level(string name, logic signed [14:0] got, logic signed [14:0] want);
      if (got !== want) report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   task automatic csr_write(logic [2:0] idx, logic [17:0] d);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = d;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_A_OFFSET:       cfg_a_offset = d[11:0];
         REG_B_OFFSET:       cfg_b_offset = d[11:0];
         REG_WINDOW_AMOUNT:  cfg_window_amount = d[10:0];
         REG_LAG_AMOUNT:     cfg_lag_amount = d[10:0];
         REG_BIPOLAR_OUTPUT: cfg_bipolar = d[0];
         REG_SAMPLE_RATE:    cfg_sample_rate = d;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic send_sample(sample_type s, bit known, levels_type want);
      levels_type lv;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.a_cv = s.a_cv;
      req_bus.a_connected = s.a_connected;
      req_bus.b_cv = s.b_cv;
      req_bus.b_connected = s.b_connected;
      req_bus.window_cv = s.window_cv;
      req_bus.window_connected = s.window_connected;
      req_bus.lag_cv = s.lag_cv;
      req_bus.lag_connected = s.lag_connected;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      lv = gate_levels_for(s);
      pending_levels.push_back(known ? want : lv);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // mostly steady words so the lag counters get to run out; a few are pure noise
   task automatic roll_sample(inout sample_type s);
      int base;
      if ($urandom_range(0, 99) < 8) begin
         s.a_cv = 16'($urandom);
         s.b_cv = 16'($urandom);
         s.window_cv = 16'($urandom);
         s.lag_cv = 16'($urandom);
         {s.a_connected, s.b_connected, s.window_connected, s.lag_connected} = 4'($urandom);
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            base = int'($urandom_range(0, 24000)) - 12000;
            s.a_cv = 16'(base);
            s.b_cv = 16'(base + int'($urandom_range(0, 16000)) - 8000);
            s.a_connected = ($urandom_range(0, 7) != 0);
            s.b_connected = ($urandom_range(0, 7) != 0);
         end
         if ($urandom_range(0, 7) == 0) begin
            s.window_cv = 16'(int'($urandom_range(0, 11000)) - 500);
            s.window_connected = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 7) == 0) begin
            s.lag_cv = 16'(int'($urandom_range(0, 11000)) - 500);
            s.lag_connected = ($urandom_range(0, 3) != 0);
         end
      end
   endtask

   // receiver side: random stalls plus a long hold-off counted here
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      levels_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_levels.size() == 0) begin
            report_mismatch("result word with no pending expectation");
         end else begin
            want = pending_levels.pop_front();
            check_level("greater_level", rsp_bus.greater_level, want.greater_level);
            check_level("less_level", rsp_bus.less_level, want.less_level);
            check_level("equal_level", rsp_bus.equal_level, want.equal_level);
            check_level("not_equal_level", rsp_bus.not_equal_level, want.not_equal_level);
         end
      end
   end

   initial begin : stimulus
      sample_type s;
      levels_type want;
      setting_type cfg;
      int idle_send [4] = '{0, 82, 0, 38};
      int idle_rsp [4] = '{0, 0, 82, 38};

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.a_cv = '0;
      req_bus.a_connected = 1'b0;
      req_bus.b_cv = '0;
      req_bus.b_connected = 1'b0;
      req_bus.window_cv = '0;
      req_bus.window_connected = 1'b0;
      req_bus.lag_cv = '0;
      req_bus.lag_connected = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 16; i++) begin
         s.a_cv = directed_tab[i].a_cv;
         s.a_connected = directed_tab[i].a_connected;
         s.b_cv = directed_tab[i].b_cv;
         s.b_connected = directed_tab[i].b_connected;
         s.window_cv = directed_tab[i].window_cv;
         s.window_connected = directed_tab[i].window_connected;
         s.lag_cv = directed_tab[i].lag_cv;
         s.lag_connected = directed_tab[i].lag_connected;
         want.greater_level = directed_tab[i].greater_level;
         want.less_level = directed_tab[i].less_level;
         want.equal_level = directed_tab[i].equal_level;
         want.not_equal_level = directed_tab[i].not_equal_level;
         send_sample(s, directed_tab[i].known, want);
      end

      for (int phase = 0; phase < 10; phase++) begin
         drain_results();
         if (phase < 5) begin
            cfg = fixed_settings[phase];
         end else begin
            cfg.a_offset = 12'(int'($urandom_range(0, 2048)) - 1024);
            cfg.b_offset = 12'(int'($urandom_range(0, 2048)) - 1024);
            if ($urandom_range(0, 3) == 0) cfg.a_offset = 12'($urandom);
            if ($urandom_range(0, 3) == 0) cfg.b_offset = 12'($urandom);
            cfg.window_amount = 11'($urandom_range(0, 1024));
            cfg.lag_amount = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                        : 11'($urandom_range(0, 1024));
            cfg.bipolar = 1'($urandom);
            cfg.sample_rate = ($urandom_range(0, 2) == 0) ? 18'($urandom)
                                                         : 18'($urandom_range(1, 48));
         end
         // unused upper data bits carry junk, the block must ignore them
         csr_write(REG_A_OFFSET, {6'($urandom), cfg.a_offset});
         csr_write(REG_B_OFFSET, {6'($urandom), cfg.b_offset});
         csr_write(REG_WINDOW_AMOUNT, {7'($urandom), cfg.window_amount});
         csr_write(REG_LAG_AMOUNT, {7'($urandom), cfg.lag_amount});
         csr_write(REG_BIPOLAR_OUTPUT, {17'($urandom), cfg.bipolar});
         csr_write(REG_SAMPLE_RATE, cfg.sample_rate);
         csr_write(SPARE_INDEX_A, 18'($urandom));
         csr_write(SPARE_INDEX_B, 18'($urandom));
         send_idle_pct = idle_send[phase % 4];
         rsp_stall_pct = idle_rsp[phase % 4];

         for (int n = 0; n < 140; n++) begin
            roll_sample(s);
            send_sample(s, 1'b0, want);
            // receiver holds off while words keep coming, so the input backs up
            if (phase % 4 == 0 && n == 40) rsp_hold = 300;
            if (n == 90) drain_results();
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_levels.size() == 0) begin
         $display("tb_window_comparator_with_lag_top passed");
      end else begin
         $display("tb_window_comparator_with_lag_top failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/wcl_pkg.sv
rtl/wcl_ifs.sv
rtl/wcl_channel.sv
rtl/window_comparator_with_lag_top.sv
tb/tb_window_comparator_with_lag_top.sv
